@@ rtl/sorted_key_offset_index_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted key offset index - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_OFFSET_INDEX_DEFINES_SVH
`define SORTED_KEY_OFFSET_INDEX_DEFINES_SVH

`ifndef SYNTHESIS
`define SKOI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_key_offset_index check failed");
`define SKOI_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted_key_offset_index check failed");
`else
`define SKOI_ASSERT(label, clk, rst, prop)
`define SKOI_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/skoi_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key offset index - package
// Shared sizes, codes and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package skoi_pkg;

  localparam int DEPTH     = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int KEY_W     = 144;
  localparam int OFF_W     = 31;
  localparam int HELD_W    = 6;
  localparam int STAT_W    = 2;
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 40;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [OFF_W-1:0] off_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic valid;
    logic at_end;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sorted_key_offset_index.sv @@
// ----------------------------------------------------------------------------
// Sorted key offset index - top level
// Sorted table of DEPTH key/offset entries: stable insert and first-match
// search. Each transaction passes through accept, a compare step in which
// every cell checks its key against the item in parallel, and an apply
// step in which the cells shift right of the insert point and the first
// matching offset is merged into the output register. One item is handled at
// a time: a new item is not taken until the last one has been applied, but
// a new item is accepted while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_offset_index_defines.svh"

module sorted_key_offset_index (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // key_bytes_high[63:0], key_bytes_middle[127:64], key_bytes_low[143:128],
  // record_offset[174:144], zero[175]
  input  wire [175:0] s_axis_tdata,
  // action[0]
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // found_offset[30:0], entries_held[36:31], zero[39:37]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);
  import skoi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              act;
  key_t              key;
  off_t              off;
  cnt_t              count;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  off_t              out_off;
  logic [HELD_W-1:0] out_held;
  logic              in_fire;
  logic              finish;
  logic              full;
  logic              ins_en;
  logic [DEPTH-1:0]  hit_vec;
  off_t              hit_off;
  logic [STAT_W-1:0] status_next;
  cnt_t              count_next;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign finish        = (state == S_APPLY) && (!out_valid || m_axis_tready);
  assign full          = count >= CNT_W'(DEPTH);
  assign ins_en        = finish && (act == ACT_INSERT) && !full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_fire) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (act == ACT_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else begin
      status_next = (|hit_vec) ? ST_FOUND : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act <= s_axis_tuser;
      key <= {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[143:128]};
      off <= s_axis_tdata[174:144];
    end
    if (finish) begin
      out_status <= status_next;
      out_off    <= (act == ACT_SEARCH) ? hit_off : '0;
      out_held   <= HELD_W'(count_next);
    end
  end

  skoi_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmp_en  (state == S_CMP),
    .ins_en  (ins_en),
    .count   (count),
    .key_in  (key),
    .off_in  (off),
    .hit_vec (hit_vec),
    .hit_off (hit_off)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_held, out_off};
  assign m_axis_tuser  = out_status;

  `SKOI_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `SKOI_ASSERT(a_accept_to_cmp, clk, rst, in_fire |=> (state == S_CMP))
  `SKOI_ASSERT(a_insert_count, clk, rst, ins_en |=> (count == $past(count) + 1'b1))
  `SKOI_ASSERT(a_single_hit, clk, rst, (state == S_APPLY) |-> $onehot0(hit_vec))

endmodule

`default_nettype wire

@@ rtl/skoi_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted key offset index - cell
// One table slot: compares against the broadcast key, shifts or loads.
// ----------------------------------------------------------------------------
`default_nettype none

module skoi_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  skoi_pkg::cell_ctl_t  ctl,
  input  skoi_pkg::key_t       key_in,
  input  skoi_pkg::off_t       off_in,
  input  skoi_pkg::key_t       nb_key,
  input  skoi_pkg::off_t       nb_off,
  input  wire                  gt_prev,
  input  wire                  eq_prev,
  output skoi_pkg::key_t       key_q,
  output skoi_pkg::off_t       off_q,
  output logic                 gt,
  output logic                 eq,
  output logic                 hit,
  output skoi_pkg::off_t       hit_off
);
  import skoi_pkg::*;

  key_t key;
  off_t off;

  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmp_en) begin
      gt <= ctl.valid && (key > key_in);
      eq <= ctl.valid && (key == key_in);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (gt_prev) begin
        key <= nb_key;
        off <= nb_off;
      end else if (gt || ctl.at_end) begin
        key <= key_in;
        off <= off_in;
      end
    end
  end

  assign hit     = eq && !eq_prev;
  assign hit_off = hit ? off : '0;
  assign key_q   = key;
  assign off_q   = off;

endmodule

`default_nettype wire

@@ rtl/skoi_chain.sv @@
// ----------------------------------------------------------------------------
// Sorted key offset index - cell chain
// Row of DEPTH cells with neighbor links and first-match offset merge.
// ----------------------------------------------------------------------------
`default_nettype none

module skoi_chain (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmp_en,
  input  wire                 ins_en,
  input  skoi_pkg::cnt_t      count,
  input  skoi_pkg::key_t      key_in,
  input  skoi_pkg::off_t      off_in,
  output logic [skoi_pkg::DEPTH-1:0] hit_vec,
  output skoi_pkg::off_t      hit_off
);
  import skoi_pkg::*;

  key_t               key_q [DEPTH];
  off_t               off_q [DEPTH];
  off_t               cell_off [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   eq;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    key_t      nb_key;
    off_t      nb_off;
    logic      gt_prev;
    logic      eq_prev;

    assign ctl.cmp_en = cmp_en;
    assign ctl.ins_en = ins_en;
    assign ctl.valid  = CNT_W'(i) < count;
    assign ctl.at_end = CNT_W'(i) == count;

    if (i == 0) begin : g_head
      assign nb_key  = key_in;
      assign nb_off  = off_in;
      assign gt_prev = 1'b0;
      assign eq_prev = 1'b0;
    end else begin : g_link
      assign nb_key  = key_q[i-1];
      assign nb_off  = off_q[i-1];
      assign gt_prev = gt[i-1];
      assign eq_prev = eq[i-1];
    end

    skoi_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .key_in  (key_in),
      .off_in  (off_in),
      .nb_key  (nb_key),
      .nb_off  (nb_off),
      .gt_prev (gt_prev),
      .eq_prev (eq_prev),
      .key_q   (key_q[i]),
      .off_q   (off_q[i]),
      .gt      (gt[i]),
      .eq      (eq[i]),
      .hit     (hit_vec[i]),
      .hit_off (cell_off[i])
    );
  end

  // at most one cell flags first match, so OR merges
  always_comb begin
    hit_off = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_off = hit_off | cell_off[i];
    end
  end

endmodule

`default_nettype wire
